### design/dssa_pkg.sv
// Shared types and constants for the dual stack core.
`default_nettype none

package dssa_pkg;

  typedef enum logic [2:0] {
    OP_PUSH1 = 3'd0,
    OP_PUSH2 = 3'd1,
    OP_POP1  = 3'd2,
    OP_POP2  = 3'd3,
    OP_PEEK1 = 3'd4,
    OP_PEEK2 = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  localparam int unsigned OpW    = 3;
  localparam int unsigned WordW  = 32;
  localparam int unsigned StatusW = 2;

  localparam logic [WordW-1:0] EmptyWord = 32'h8000_0000;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic load_out;  // move result into the output register
  } dssa_cmd_t;

endpackage

`default_nettype wire

### design/dssa_ctrl.sv
// Controller: sequences accept, store access and result hand-off.
`default_nettype none

module dssa_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output dssa_pkg::dssa_cmd_t   cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  // output register frees up in the same cycle it is taken
  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;

  assign cmd_o.accept   = accept;
  assign cmd_o.load_out = (state_q == S_RESP);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == S_RESP) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### design/dssa_dp.sv
// Datapath: shared word store, both stack pointers and the result register.
`default_nettype none

module dssa_dp #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dssa_pkg::dssa_cmd_t           cmd_i,
  input  wire logic [dssa_pkg::OpW-1:0]      opcode_i,
  input  wire logic [dssa_pkg::WordW-1:0]    push_value_i,
  output logic      [dssa_pkg::WordW-1:0]    read_value_o,
  output logic      [dssa_pkg::StatusW-1:0]  status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] Top = PW'(DEPTH);
  localparam logic [PW-1:0] One = PW'(1);

  logic [dssa_pkg::WordW-1:0] mem [DEPTH];

  logic [PW-1:0] lower_q, lower_d;
  logic [PW-1:0] upper_q, upper_d;

  logic                         full, empty1, empty2;
  logic                         wr_en, rd_en;
  logic [PW-1:0]                addr;
  logic                         use_rd_d;
  logic [dssa_pkg::WordW-1:0]   res_value_d;
  dssa_pkg::status_e            res_status_d;

  logic                         use_rd_q;
  logic [dssa_pkg::WordW-1:0]   res_value_q;
  dssa_pkg::status_e            res_status_q;
  logic [dssa_pkg::WordW-1:0]   rdata_q;
  logic [dssa_pkg::WordW-1:0]   out_value_q;
  logic [dssa_pkg::StatusW-1:0] out_status_q;

  assign full   = (lower_q >= upper_q);
  assign empty1 = (lower_q == '0);
  assign empty2 = (upper_q == Top);

  always_comb begin
    lower_d      = lower_q;
    upper_d      = upper_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    addr         = lower_q;
    use_rd_d     = 1'b0;
    res_value_d  = '0;
    res_status_d = dssa_pkg::ST_OK;
    unique case (opcode_i)
      dssa_pkg::OP_PUSH1: begin
        if (full) begin
          res_status_d = dssa_pkg::ST_OVERFLOW;
        end else begin
          wr_en   = 1'b1;
          addr    = lower_q;
          lower_d = lower_q + One;
        end
      end
      dssa_pkg::OP_PUSH2: begin
        if (full) begin
          res_status_d = dssa_pkg::ST_OVERFLOW;
        end else begin
          wr_en   = 1'b1;
          addr    = upper_q - One;
          upper_d = upper_q - One;
        end
      end
      dssa_pkg::OP_POP1, dssa_pkg::OP_PEEK1: begin
        if (empty1) begin
          res_value_d  = dssa_pkg::EmptyWord;
          res_status_d = dssa_pkg::ST_UNDERFLOW;
        end else begin
          rd_en    = 1'b1;
          use_rd_d = 1'b1;
          addr     = lower_q - One;
          if (opcode_i == dssa_pkg::OP_POP1) lower_d = lower_q - One;
        end
      end
      dssa_pkg::OP_POP2, dssa_pkg::OP_PEEK2: begin
        if (empty2) begin
          res_value_d  = dssa_pkg::EmptyWord;
          res_status_d = dssa_pkg::ST_UNDERFLOW;
        end else begin
          rd_en    = 1'b1;
          use_rd_d = 1'b1;
          addr     = upper_q;
          if (opcode_i == dssa_pkg::OP_POP2) upper_d = upper_q + One;
        end
      end
      default: ;  // unused codes: no effect, zero result, ok
    endcase
  end

  // word store, one port, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) begin
      mem[addr[AW-1:0]] <= push_value_i;
    end
    if (cmd_i.accept && rd_en) begin
      rdata_q <= mem[addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= Top;
    end else if (cmd_i.accept) begin
      lower_q <= lower_d;
      upper_q <= upper_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      use_rd_q     <= use_rd_d;
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
    end
    if (cmd_i.load_out) begin
      out_value_q  <= use_rd_q ? rdata_q : res_value_q;
      out_status_q <= res_status_q;
    end
  end

  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;

endmodule

`default_nettype wire

### design/dual_stack_shared_array_core.sv
// Top level: two stacks sharing one word store, stream in and stream out.
`default_nettype none

// Two LIFO stacks live in one store of DEPTH 32-bit words: stack one fills
// upward from entry 0, stack two downward from entry DEPTH-1. Each input beat
// (tuser: opcode push1/push2/pop1/pop2/peek1/peek2, tdata: word to push) gives
// exactly one output beat (tdata: popped or peeked word, tuser: status ok,
// overflow or underflow). A push when the stacks meet is refused with
// overflow; a pop or peek of an empty stack returns 0x80000000 with underflow.
// Each item first accesses the single-port store, then its result (the registered
// read data for a pop or peek) moves into the output register. A new beat is
// taken while the previous result waits, provided the output register is taken
// in that cycle. No clearing pass is needed after reset.
module dual_stack_shared_array_core #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [31:0]                   s_axis_tdata_i,  // [31:0] push_value
  input  wire logic [dssa_pkg::OpW-1:0]      s_axis_tuser_i,  // [2:0] opcode
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic      [31:0]                   m_axis_tdata_o,  // [31:0] read_value
  output logic      [dssa_pkg::StatusW-1:0]  m_axis_tuser_o   // [1:0] status
);

  dssa_pkg::dssa_cmd_t cmd;

  dssa_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd)
  );

  dssa_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (s_axis_tuser_i),
    .push_value_i (s_axis_tdata_i),
    .read_value_o (m_axis_tdata_o),
    .status_o     (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

### tb/tb_dual_stack_shared_array_core.sv
// Self-checking testbench for the dual stack core: directed table, random phases, scoreboard.
module tb_dual_stack_shared_array_core;

  localparam int unsigned DEPTH       = 128;
  localparam int          NumDirected = 23;
  localparam int          RandomItems = 700;
  localparam int          CycleLimit  = 500000;
  localparam int          DrainCycles = 16;

  // opcodes outside the defined set; the core must answer them with ok and zero
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  localparam int PhaseFill  = 0;
  localparam int PhaseDrain = 1;
  localparam int PhaseMixed = 2;

  typedef struct packed {
    logic [dssa_pkg::WordW-1:0] rv;
    dssa_pkg::status_e          st;
  } stack_result_t;

  typedef struct packed {
    logic [dssa_pkg::OpW-1:0]   op;
    logic [dssa_pkg::WordW-1:0] word;
    logic                       typed;
    logic [dssa_pkg::WordW-1:0] rv;
    dssa_pkg::status_e          st;
  } dir_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [31:0]                    s_axis_tdata_i;   // [31:0] push_value
  logic [dssa_pkg::OpW-1:0]       s_axis_tuser_i;   // [2:0] opcode
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  logic [31:0]                    m_axis_tdata_o;   // [31:0] read_value
  logic [dssa_pkg::StatusW-1:0]   m_axis_tuser_o;   // [1:0] status

  // mirror of the two stacks
  logic [dssa_pkg::WordW-1:0]     mirror_store [DEPTH];
  int unsigned                    lower_fill;
  int unsigned                    upper_edge;

  stack_result_t                  pending_results [$];
  dir_row_t                       dir_rows [NumDirected];

  logic                           row_typed;
  logic [dssa_pkg::WordW-1:0]     row_rv;
  dssa_pkg::status_e              row_st;

  int                             mismatches;
  int                             cycle_count;
  bit                             src_calm;
  bit                             sink_calm;
  int                             sink_hold;

  dual_stack_shared_array_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch @%0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // next state and result of the two stacks for one operation
  task automatic apply_stack_op(input logic [dssa_pkg::OpW-1:0] op,
                                input logic [dssa_pkg::WordW-1:0] word,
                                output logic [dssa_pkg::WordW-1:0] rv,
                                output dssa_pkg::status_e st);
    rv = '0;
    st = dssa_pkg::ST_OK;
    case (op)
      dssa_pkg::OP_PUSH1: begin
        if (lower_fill >= upper_edge) begin
          st = dssa_pkg::ST_OVERFLOW;
        end else begin
          mirror_store[lower_fill] = word;
          lower_fill++;
        end
      end
      dssa_pkg::OP_PUSH2: begin
        if (lower_fill >= upper_edge) begin
          st = dssa_pkg::ST_OVERFLOW;
        end else begin
          upper_edge--;
          mirror_store[upper_edge] = word;
        end
      end
      dssa_pkg::OP_POP1, dssa_pkg::OP_PEEK1: begin
        if (lower_fill == 0) begin
          rv = dssa_pkg::EmptyWord;
          st = dssa_pkg::ST_UNDERFLOW;
        end else begin
          rv = mirror_store[lower_fill-1];
          if (op == dssa_pkg::OP_POP1) lower_fill--;
        end
      end
      dssa_pkg::OP_POP2, dssa_pkg::OP_PEEK2: begin
        if (upper_edge >= DEPTH) begin
          rv = dssa_pkg::EmptyWord;
          st = dssa_pkg::ST_UNDERFLOW;
        end else begin
          rv = mirror_store[upper_edge];
          if (op == dssa_pkg::OP_POP2) upper_edge++;
        end
      end
      default: ;
    endcase
  endtask

  // idle stretch: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [dssa_pkg::WordW-1:0] draw_word();
    case ($urandom_range(19))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // scoreboard: result beats first, then the input beat taken at the same edge
  always @(posedge clk_i) begin
    stack_result_t want;
    logic [dssa_pkg::WordW-1:0] rv;
    dssa_pkg::status_e st;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat data %h status %0d",
                                    m_axis_tdata_o, m_axis_tuser_o));
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata_o !== want.rv)
            report_mismatch($sformatf("read_value %h, expected %h", m_axis_tdata_o, want.rv));
          if (m_axis_tuser_o !== want.st)
            report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser_o, want.st));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        apply_stack_op(s_axis_tuser_i, s_axis_tdata_i, rv, st);
        if (row_typed) begin
          rv = row_rv;
          st = row_st;
        end
        pending_results.push_back('{rv: rv, st: st});
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("dual_stack_shared_array_core regression: fail");
    $finish;
  end

  // result side back-pressure
  initial begin
    m_axis_tready_i = 1'b0;
    sink_calm = 1'b0;
    sink_hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready_i = 1'b0;
      end else begin
        if ($urandom_range(299) == 0) sink_calm = !sink_calm;
        if (!sink_calm && $urandom_range(99) < 20) begin
          sink_hold = idle_len() - 1;
          m_axis_tready_i = 1'b0;
        end else begin
          m_axis_tready_i = 1'b1;
        end
      end
    end
  end

  // present one beat, holding valid high across back-to-back beats
  task automatic send_beat(input logic [dssa_pkg::OpW-1:0] op,
                           input logic [dssa_pkg::WordW-1:0] word,
                           input logic typed, input logic [dssa_pkg::WordW-1:0] trv,
                           input dssa_pkg::status_e tst);
    int gap;
    gap = (src_calm || $urandom_range(99) < 65) ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = word;
    row_typed       = typed;
    row_rv          = trv;
    row_st          = tst;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int phase_len;
    int phase_kind;
    int bias;
    int r;
    logic [dssa_pkg::OpW-1:0] op;
    bit first_side;

    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    row_typed       = 1'b0;
    row_rv          = '0;
    row_st          = dssa_pkg::ST_OK;
    mismatches      = 0;
    src_calm        = 1'b0;
    lower_fill      = 0;
    upper_edge      = DEPTH;

    dir_rows[0]  = '{dssa_pkg::OP_POP1,  32'h0000_0000, 1'b1,
                     dssa_pkg::EmptyWord, dssa_pkg::ST_UNDERFLOW};
    dir_rows[1]  = '{dssa_pkg::OP_POP2,  32'hFFFF_FFFF, 1'b1,
                     dssa_pkg::EmptyWord, dssa_pkg::ST_UNDERFLOW};
    dir_rows[2]  = '{dssa_pkg::OP_PEEK1, 32'h0000_0000, 1'b1,
                     dssa_pkg::EmptyWord, dssa_pkg::ST_UNDERFLOW};
    dir_rows[3]  = '{dssa_pkg::OP_PEEK2, 32'h5A5A_5A5A, 1'b1,
                     dssa_pkg::EmptyWord, dssa_pkg::ST_UNDERFLOW};
    dir_rows[4]  = '{dssa_pkg::OP_PUSH1, 32'h7FFF_FFFF, 1'b1, 32'h0, dssa_pkg::ST_OK};
    dir_rows[5]  = '{dssa_pkg::OP_PUSH2, 32'h8000_0000, 1'b1, 32'h0, dssa_pkg::ST_OK};
    dir_rows[6]  = '{dssa_pkg::OP_PUSH1, 32'hFFFF_FFFF, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[7]  = '{dssa_pkg::OP_PUSH2, 32'h0000_0000, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[8]  = '{dssa_pkg::OP_PEEK1, 32'hA5A5_A5A5, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[9]  = '{dssa_pkg::OP_PEEK2, 32'h0000_0000, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[10] = '{dssa_pkg::OP_POP1,  32'h0000_0000, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[11] = '{dssa_pkg::OP_POP1,  32'hFFFF_FFFF, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[12] = '{dssa_pkg::OP_POP1,  32'h0000_0000, 1'b1,
                     dssa_pkg::EmptyWord, dssa_pkg::ST_UNDERFLOW};
    dir_rows[13] = '{dssa_pkg::OP_POP2,  32'h0000_0000, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[14] = '{dssa_pkg::OP_POP2,  32'hFFFF_FFFF, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[15] = '{dssa_pkg::OP_POP2,  32'h0000_0000, 1'b1,
                     dssa_pkg::EmptyWord, dssa_pkg::ST_UNDERFLOW};
    dir_rows[16] = '{OpSpare6, 32'hFFFF_FFFF, 1'b1, 32'h0, dssa_pkg::ST_OK};
    dir_rows[17] = '{OpSpare7, 32'h1234_5678, 1'b1, 32'h0, dssa_pkg::ST_OK};
    dir_rows[18] = '{dssa_pkg::OP_PUSH1, 32'h0000_0001, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[19] = '{dssa_pkg::OP_PUSH2, 32'hFFFF_FFFE, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[20] = '{dssa_pkg::OP_PEEK1, 32'h0000_0000, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[21] = '{dssa_pkg::OP_PEEK2, 32'h0000_0000, 1'b0, 32'h0, dssa_pkg::ST_OK};
    dir_rows[22] = '{dssa_pkg::OP_POP2,  32'h0000_0000, 1'b0, 32'h0, dssa_pkg::ST_OK};

    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      send_beat(dir_rows[i].op, dir_rows[i].word, dir_rows[i].typed,
                dir_rows[i].rv, dir_rows[i].st);
    end
    // hold off until every result is back before the random phases
    wait_drained();

    sent = 0;
    phase_kind = PhaseFill;
    phase_len = 220;
    while (sent < RandomItems) begin
      bias = $urandom_range(100);
      src_calm = ($urandom_range(3) == 0);
      for (int k = 0; k < phase_len && sent < RandomItems; k++) begin
        r = $urandom_range(99);
        first_side = ($urandom_range(99) < bias);
        sent++;
        if (r < 2) begin
          op = $urandom_range(1) ? OpSpare7 : OpSpare6;
        end else begin
          r = $urandom_range(99);
          case (phase_kind)
            PhaseFill:
              op = (r < 85) ? (first_side ? dssa_pkg::OP_PUSH1 : dssa_pkg::OP_PUSH2) :
                   (r < 95) ? (first_side ? dssa_pkg::OP_POP1 : dssa_pkg::OP_POP2) :
                              (first_side ? dssa_pkg::OP_PEEK1 : dssa_pkg::OP_PEEK2);
            PhaseDrain:
              op = (r < 75) ? (first_side ? dssa_pkg::OP_POP1 : dssa_pkg::OP_POP2) :
                   (r < 90) ? (first_side ? dssa_pkg::OP_PEEK1 : dssa_pkg::OP_PEEK2) :
                              (first_side ? dssa_pkg::OP_PUSH1 : dssa_pkg::OP_PUSH2);
            default:
              op = (r < 45) ? (first_side ? dssa_pkg::OP_PUSH1 : dssa_pkg::OP_PUSH2) :
                   (r < 80) ? (first_side ? dssa_pkg::OP_POP1 : dssa_pkg::OP_POP2) :
                              (first_side ? dssa_pkg::OP_PEEK1 : dssa_pkg::OP_PEEK2);
          endcase
        end
        send_beat(op, draw_word(), 1'b0, '0, dssa_pkg::ST_OK);
      end
      if ($urandom_range(2) == 0) wait_drained();
      phase_kind = $urandom_range(PhaseMixed);
      phase_len = $urandom_range(60, 200);
    end

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("dual_stack_shared_array_core regression: pass");
    end else begin
      $display("dual_stack_shared_array_core regression: fail");
    end
    $finish;
  end

endmodule

### files.f
design/dssa_pkg.sv
design/dssa_ctrl.sv
design/dssa_dp.sv
design/dual_stack_shared_array_core.sv
tb/tb_dual_stack_shared_array_core.sv
